FILE: hdl/assert_macros.svh
// Assertion helpers for the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

FILE: hdl/mpf_pkg.sv
package mpf_pkg;
  localparam int unsigned DATA_WIDTH = 31;
  localparam int unsigned STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNBOUNDED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
  localparam int unsigned QUEUE_DEPTH = 2;
endpackage

FILE: hdl/mpf_if.sv
interface mpf_in_if #(parameter int unsigned W = mpf_pkg::DATA_WIDTH);
  logic valid;
  logic ready;
  logic [W-1:0] n_value;
  logic [W-1:0] k_base;
  modport source (output valid, output n_value, output k_base, input ready);
  modport sink (input valid, input n_value, input k_base, output ready);
endinterface

interface mpf_out_if #(parameter int unsigned W = mpf_pkg::DATA_WIDTH);
  logic valid;
  logic ready;
  logic [W-1:0] exponent;
  logic [mpf_pkg::STATUS_W-1:0] status;
  modport source (output valid, output exponent, output status, input ready);
  modport sink (input valid, input exponent, input status, output ready);
endinterface

FILE: hdl/mpf_front.sv
// Classify requests by k (zero, one or larger) and queue every request as work with its kind.
module mpf_front #(
  parameter int unsigned W = mpf_pkg::DATA_WIDTH,
  parameter int unsigned DEPTH = mpf_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_n,
  input  logic [W-1:0] in_k,
  output logic         q_valid,
  input  logic         q_ready,
  output logic [W-1:0] q_n,
  output logic [W-1:0] q_k,
  output logic [1:0]   q_kind
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [W-1:0] n_mem [DEPTH];
  logic [W-1:0] k_mem [DEPTH];
  logic [1:0]   c_mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic push, pop;
  logic [1:0] kind;

  always_comb begin
    if (in_k == '0) kind = mpf_pkg::ST_INVALID;
    else if (in_k == W'(1)) kind = mpf_pkg::ST_UNBOUNDED;
    else kind = mpf_pkg::ST_OK;
  end

  assign in_ready = (cnt_r != (AW+1)'(DEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != '0);
  assign pop = q_valid && q_ready;
  assign q_n = n_mem[rp_r];
  assign q_k = k_mem[rp_r];
  assign q_kind = c_mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      n_mem[wp_r] <= in_n;
      k_mem[wp_r] <= in_k;
      c_mem[wp_r] <= kind;
    end
  end
endmodule

FILE: hdl/mpf_divider.sv
// Restoring divider, one quotient bit per cycle.
module mpf_divider #(
  parameter int unsigned W = mpf_pkg::DATA_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int unsigned CW = $clog2(W+1);
  logic [W-1:0] q_r, d_r;
  logic [W:0]   r_r;
  logic [CW-1:0] cnt_r;
  logic busy_r, done_r;
  logic [W:0] trial;
  logic [W:0] shifted;

  assign shifted = {r_r[W-1:0], q_r[W-1]};
  assign trial = shifted - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      d_r <= divisor;
      r_r <= '0;
    end else if (busy_r) begin
      if (!trial[W]) begin
        r_r <= trial;
        q_r <= {q_r[W-2:0], 1'b1};
      end else begin
        r_r <= shifted;
        q_r <= {q_r[W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem = r_r[W-1:0];
endmodule

FILE: hdl/mpf_back.sv
// Factor k by trial division and apply Legendre's formula per prime; k of zero or one is settled without division.
module mpf_back #(
  parameter int unsigned W = mpf_pkg::DATA_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  output logic         q_ready,
  input  logic [W-1:0] q_n,
  input  logic [W-1:0] q_k,
  input  logic [1:0]   q_kind,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_exponent,
  output logic [1:0]   out_status
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHK    = 9'b000000010,
    S_DIVK   = 9'b000000100,
    S_MULT   = 9'b000001000,
    S_LEG    = 9'b000010000,
    S_LEGW   = 9'b000100000,
    S_FIN    = 9'b001000000,
    S_DIVE   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state_r;
  logic [W-1:0] n_r, rest_r, p_r, best_r, mult_r, cnt_r, ln_r;
  logic last_r;
  logic div_start, div_done;
  logic [W-1:0] div_a, div_b, quot, rem;
  logic [W-1:0] cand;

  mpf_divider #(.W(W)) u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quot, .rem
  );

  assign q_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_exponent = best_r;
  assign cand = (mult_r == '0) ? cnt_r : quot;

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            n_r <= q_n;
            rest_r <= q_k;
            p_r <= W'(2);
            best_r <= '1;
            out_status <= q_kind;
            if (q_kind == mpf_pkg::ST_INVALID) begin
              best_r <= '0;
              state_r <= S_OUT;
            end else if (q_kind == mpf_pkg::ST_UNBOUNDED) begin
              state_r <= S_OUT;
            end else begin
              div_a <= q_k;
              div_b <= W'(2);
              div_start <= 1'b1;
              state_r <= S_CHK;
            end
          end
        end
        S_CHK: begin
          // loop continues while p <= rest / p
          if (div_done) begin
            if (p_r > quot) begin
              last_r <= 1'b1;
              if (rest_r > W'(1)) begin
                p_r <= rest_r;
                mult_r <= '0;
                cnt_r <= '0;
                ln_r <= n_r;
                state_r <= S_LEG;
              end else state_r <= S_OUT;
            end else if (rem == '0) begin
              mult_r <= '0;
              div_a <= rest_r;
              div_b <= p_r;
              div_start <= 1'b1;
              state_r <= S_DIVK;
            end else begin
              p_r <= p_r + 1'b1;
              div_a <= rest_r;
              div_b <= p_r + 1'b1;
              div_start <= 1'b1;
            end
          end
        end
        S_DIVK: begin
          if (div_done) begin
            if (rem == '0) begin
              mult_r <= mult_r + 1'b1;
              rest_r <= quot;
              div_a <= quot;
              div_b <= p_r;
              div_start <= 1'b1;
            end else begin
              cnt_r <= '0;
              ln_r <= n_r;
              last_r <= 1'b0;
              state_r <= S_LEG;
            end
          end
        end
        S_LEG: begin
          if (ln_r == '0) state_r <= S_FIN;
          else begin
            div_a <= ln_r;
            div_b <= p_r;
            div_start <= 1'b1;
            state_r <= S_LEGW;
          end
        end
        S_LEGW: begin
          if (div_done) begin
            ln_r <= quot;
            cnt_r <= cnt_r + quot;
            state_r <= S_LEG;
          end
        end
        S_FIN: begin
          if (cnt_r == '0) begin
            best_r <= '0;
            state_r <= S_OUT;
          end else if (mult_r == '0) begin
            if (cnt_r < best_r) best_r <= cnt_r;
            state_r <= S_OUT;
          end else begin
            div_a <= cnt_r;
            div_b <= mult_r;
            div_start <= 1'b1;
            state_r <= S_DIVE;
          end
        end
        S_DIVE: begin
          if (div_done) begin
            if (cand < best_r) best_r <= cand;
            p_r <= p_r + 1'b1;
            div_a <= rest_r;
            div_b <= p_r + 1'b1;
            div_start <= 1'b1;
            state_r <= last_r ? S_OUT : S_CHK;
          end
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/max_power_of_k_in_factorial.sv
// Flow: each request passes through the queue; k of zero or one goes straight to
// the output, otherwise the divider is used for each trial divisor up to sqrt(k)
// and for each Legendre step.
// Throughput: one request at a time in the back end, set by the shared divider.
// Reset: synchronous, active low; clears the queue pointers and the sequencer.
`include "assert_macros.svh"
module max_power_of_k_in_factorial #(
  parameter int unsigned DATA_WIDTH = mpf_pkg::DATA_WIDTH,
  parameter int unsigned QUEUE_DEPTH = mpf_pkg::QUEUE_DEPTH
) (
  input logic clk,
  input logic rst_n,
  mpf_in_if.sink in_ch,
  mpf_out_if.source out_ch
);
  logic q_valid, q_ready;
  logic [DATA_WIDTH-1:0] q_n, q_k;
  logic [1:0] q_kind;

  // Front: classify trivial bases, hold pending requests in a short queue.
  mpf_front #(.W(DATA_WIDTH), .DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_n(in_ch.n_value), .in_k(in_ch.k_base),
    .q_valid, .q_ready, .q_n, .q_k, .q_kind
  );

  // Back: factorise and count, drive the result register.
  mpf_back #(.W(DATA_WIDTH)) u_back (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_n, .q_k, .q_kind,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_exponent(out_ch.exponent), .out_status(out_ch.status)
  );

  `ASSERT_IMPL(a_unb_max, clk, rst_n,
    out_ch.valid && out_ch.status == mpf_pkg::ST_UNBOUNDED, &out_ch.exponent)
  `ASSERT_IMPL(a_inv_zero, clk, rst_n,
    out_ch.valid && out_ch.status == mpf_pkg::ST_INVALID, out_ch.exponent == '0)
  `ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule
